// ===== hdl/camera_point_project_radtan_unit_defines.svh =====
// assertion macros shared by the project
`ifndef CAMERA_POINT_PROJECT_RADTAN_UNIT_DEFINES_SVH
`define CAMERA_POINT_PROJECT_RADTAN_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CPRT_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define CPRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CPRT_ASSERT_NOW(label, cond)
`define CPRT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/cprt_pkg.sv =====
package cprt_pkg;

  localparam int DivBits = 33;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] REG_FOCAL_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FOCAL_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRINCIPAL = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_K1 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_K2 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_K3 = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_P1 = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_P2 = 3'd7;

  typedef struct packed {
    logic [30:0]        rem;
    logic [DivBits-1:0] d;
    logic [DivBits-1:0] q;
    logic               neg;
    logic               ovf;
  } div_lane_t;

  typedef struct packed {
    logic      valid;
    logic      front;
    logic [30:0] z;
    div_lane_t lx;
    div_lane_t ly;
  } div_item_t;

  typedef struct packed {
    logic [23:0]        fx;
    logic [23:0]        fy;
    logic [23:0]        cx;
    logic [23:0]        cy;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } cfg_t;

  typedef struct packed {
    logic               front;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic signed [31:0] xy;
    logic signed [31:0] r2;
    logic signed [31:0] r4;
    logic signed [31:0] r6;
    logic signed [31:0] xy2;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] m1;
    logic signed [31:0] m2;
    logic signed [31:0] m3;
    logic signed [31:0] ax;
    logic signed [31:0] bx;
    logic signed [31:0] ay;
    logic signed [31:0] by;
    logic signed [31:0] radial;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] xd;
    logic signed [31:0] yd;
  } math_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] mulq24(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd8388608;
    return sat32(p >>> 24);
  endfunction

  function automatic logic signed [31:0] mulq28(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd134217728;
    return sat32(p >>> 28);
  endfunction

endpackage

// ===== hdl/cprt_div_cell.sv =====
module cprt_div_cell
  import cprt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  div_item_t din,
  output div_item_t dout
);

  function automatic div_lane_t step(input div_lane_t l, input logic [30:0] z);
    div_lane_t  o;
    logic [31:0] r;
    logic       ge;
    r = {l.rem, l.d[DivBits-1]};
    ge = r >= {1'b0, z};
    o = l;
    o.rem = ge ? 31'(r - {1'b0, z}) : r[30:0];
    o.d = {l.d[DivBits-2:0], 1'b0};
    o.q = {l.q[DivBits-2:0], ge};
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout.valid <= din.valid;
    end
    if (adv) begin
      dout.front <= din.front;
      dout.z <= din.z;
      dout.lx <= step(din.lx, din.z);
      dout.ly <= step(din.ly, din.z);
    end
  end

endmodule

// ===== hdl/cprt_math.sv =====
module cprt_math
  import cprt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  cfg_t             cfg,
  input  div_item_t        din,
  output logic             out_valid,
  output logic signed [23:0] out_u,
  output logic signed [23:0] out_v,
  output logic             out_front
);

  localparam int Stages = 9;

  logic [Stages-1:0] vld;
  math_t s1, s2, s3, s4, s5, s6, s7, s8, s9;
  math_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next, s7_next, s8_next, s9_next;

  function automatic logic signed [31:0] finish(input div_lane_t l);
    logic big;
    big = l.ovf | l.q[32] | l.q[31];
    if (big) begin
      return l.neg ? 32'sh80000000 : 32'sh7fffffff;
    end
    return l.neg ? -$signed(l.q[31:0]) : $signed(l.q[31:0]);
  endfunction

  function automatic logic signed [23:0] pix(input logic [23:0] f,
                                             input logic signed [31:0] d,
                                             input logic [23:0] c);
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = 64'($signed({1'b0, f})) * 64'(d) + 64'sd8388608;
    s = (p >>> 24) + 64'($signed({1'b0, c}));
    if (s > 64'sd8388607) begin
      return 24'sh7fffff;
    end else if (s < -64'sd8388608) begin
      return 24'sh800000;
    end
    return s[23:0];
  endfunction

  logic signed [31:0] r2c;
  assign r2c = sat32(64'(s2.x2) + 64'(s2.y2));

  always_comb begin
    s1_next = '0;
    s1_next.front = din.front;
    s1_next.x = finish(din.lx);
    s1_next.y = finish(din.ly);

    s2_next = s1;
    s2_next.x2 = mulq24(s1.x, s1.x);
    s2_next.y2 = mulq24(s1.y, s1.y);
    s2_next.xy = mulq24(s1.x, s1.y);

    s3_next = s2;
    s3_next.r2 = r2c;
    s3_next.xy2 = sat32(64'(s2.xy) * 64'sd2);
    s3_next.tx = sat32(64'(r2c) + 64'(s2.x2) * 64'sd2);
    s3_next.ty = sat32(64'(r2c) + 64'(s2.y2) * 64'sd2);

    s4_next = s3;
    s4_next.r4 = mulq24(s3.r2, s3.r2);

    s5_next = s4;
    s5_next.r6 = mulq24(s4.r4, s4.r2);
    s5_next.m1 = mulq28(cfg.k1, s4.r2);
    s5_next.m2 = mulq28(cfg.k2, s4.r4);
    s5_next.ax = mulq28(cfg.p1, s4.xy2);
    s5_next.bx = mulq28(cfg.p2, s4.tx);
    s5_next.ay = mulq28(cfg.p2, s4.xy2);
    s5_next.by = mulq28(cfg.p1, s4.ty);

    s6_next = s5;
    s6_next.m3 = mulq28(cfg.k3, s5.r6);

    s7_next = s6;
    s7_next.radial = sat32(64'sd16777216 + 64'(s6.m1) + 64'(s6.m2) + 64'(s6.m3));

    s8_next = s7;
    s8_next.mx = mulq24(s7.x, s7.radial);
    s8_next.my = mulq24(s7.y, s7.radial);

    s9_next = s8;
    s9_next.xd = sat32(64'(s8.mx) + 64'(s8.ax) + 64'(s8.bx));
    s9_next.yd = sat32(64'(s8.my) + 64'(s8.ay) + 64'(s8.by));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[Stages-2:0], din.valid};
      out_valid <= vld[Stages-1];
    end
    if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
      s6 <= s6_next;
      s7 <= s7_next;
      s8 <= s8_next;
      s9 <= s9_next;

      out_front <= s9.front;
      out_u <= s9.front ? pix(cfg.fx, s9.xd, cfg.cx) : '0;
      out_v <= s9.front ? pix(cfg.fy, s9.yd, cfg.cy) : '0;
    end
  end

endmodule

// ===== hdl/camera_point_project_radtan_unit.sv =====
// Radial-tangential pinhole projection, one point per clock unless stalled.
// Input channel: point_valid / point_stall with point_x, point_y, point_z
// (signed Q16.16). A request is taken on a rising edge with valid high and
// stall low.
// Output channel: pixel_valid / pixel_stall with pixel_u, pixel_v (signed
// Q16.8, saturated) and in_front. A point with depth <= 0 gives zero pixels
// and in_front low.
// The two divisions run in a chain of 33 cells, one quotient bit per cell,
// followed by ten arithmetic stages ending in the output register.
// Throughput: one point per cycle while the output is taken.
// When pixel_stall is high with a result pending, the whole pipeline holds
// and point_stall is raised in the same cycle.
// Configuration: cfg_write / cfg_index / cfg_data, written by the user only
// while idle; the block does not enforce it. Reset clears the pipeline
// valids and sets focal lengths 1.0, principal point and coefficients 0.
`include "camera_point_project_radtan_unit_defines.svh"

module camera_point_project_radtan_unit
  import cprt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                point_valid,
  output logic                point_stall,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  output logic                pixel_valid,
  input  logic                pixel_stall,
  output logic signed [23:0]  pixel_u,
  output logic signed [23:0]  pixel_v,
  output logic                in_front
);

  cfg_t cfg;
  logic adv;

  assign adv = !pixel_valid || !pixel_stall;
  assign point_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fx <= 24'd256;
      cfg.fy <= 24'd256;
      cfg.cx <= '0;
      cfg.cy <= '0;
      cfg.k1 <= '0;
      cfg.k2 <= '0;
      cfg.k3 <= '0;
      cfg.p1 <= '0;
      cfg.p2 <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FOCAL_X: cfg.fx <= cfg_data[23:0];
        REG_FOCAL_Y: cfg.fy <= cfg_data[23:0];
        REG_PRINCIPAL: begin
          cfg.cx <= cfg_data[23:0];
          cfg.cy <= cfg_data[47:24];
        end
        REG_K1: cfg.k1 <= cfg_data[31:0];
        REG_K2: cfg.k2 <= cfg_data[31:0];
        REG_K3: cfg.k3 <= cfg_data[31:0];
        REG_P1: cfg.p1 <= cfg_data[31:0];
        REG_P2: cfg.p2 <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic        front;
  logic [30:0] zp;

  assign front = point_z > 32'sd0;
  assign zp = front ? point_z[30:0] : 31'd1;

  function automatic div_lane_t prep(input logic signed [31:0] n,
                                     input logic [30:0] z);
    div_lane_t   l;
    logic [31:0] an;
    logic [55:0] dd;
    logic [30:0] hi;
    an = n[31] ? 32'(-n) : 32'(n);
    dd = {an, 24'd0} + 56'(z[30:1]);
    hi = 31'(dd[55:33]);
    l.ovf = hi >= z;
    l.rem = l.ovf ? '0 : hi;
    l.d = dd[32:0];
    l.q = '0;
    l.neg = n[31];
    return l;
  endfunction

  div_item_t chain [0:DivBits];

  assign chain[0].valid = point_valid;
  assign chain[0].front = front;
  assign chain[0].z = zp;
  assign chain[0].lx = prep(point_x, zp);
  assign chain[0].ly = prep(point_y, zp);

  for (genvar i = 0; i < DivBits; i++) begin : g_div
    cprt_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  cprt_math u_math (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .din       (chain[DivBits]),
    .out_valid (pixel_valid),
    .out_u     (pixel_u),
    .out_v     (pixel_v),
    .out_front (in_front)
  );

  `CPRT_ASSERT_NOW(a_behind_zero, !(pixel_valid && !in_front) || (pixel_u == 0 && pixel_v == 0))
  `CPRT_ASSERT_NOW(a_empty_no_stall, pixel_valid || !point_stall)
  `CPRT_ASSERT_NEXT(a_hold, pixel_valid && pixel_stall, pixel_valid && $stable(pixel_u))

endmodule
